// File: hw/rtl/sau_pkg.sv
// ---------------------------------------------------------------------------
// sau_pkg: shared types, constants and decode for the SPR access unit
// Holds architectural SPR numbers, capability bit positions and the
// number-to-entry decode used by the top level.
// ---------------------------------------------------------------------------
`default_nettype none

package sau_pkg;

	// field widths fixed by the instruction format
	localparam int NUM_W = 10;
	localparam int GPR_W = 5;
	localparam int VAL_W = 32;
	localparam int CAP_W = 6;
	localparam int IDX_W = 6;
	localparam int GATE_W = 3;

	// parameter defaults
	localparam int SPR_ENTRIES_DEF = 64;
	localparam int DATA_WIDTH_DEF = 32;

	// action codes
	localparam logic ACT_MTSPR = 1'b0;
	localparam logic ACT_MFSPR = 1'b1;

	// capability mask bit positions
	localparam logic [GATE_W-1:0] CAP_HID2 = 3'd0;
	localparam logic [GATE_W-1:0] CAP_HID4 = 3'd1;
	localparam logic [GATE_W-1:0] CAP_UBAT = 3'd2;
	localparam logic [GATE_W-1:0] CAP_GQR = 3'd3;
	localparam logic [GATE_W-1:0] CAP_L2CR = 3'd4;
	localparam logic [GATE_W-1:0] CAP_PMON = 3'd5;

	// architectural SPR numbers
	localparam logic [NUM_W-1:0] SPR_XER = 10'd1;
	localparam logic [NUM_W-1:0] SPR_LR = 10'd8;
	localparam logic [NUM_W-1:0] SPR_CTR = 10'd9;
	localparam logic [NUM_W-1:0] SPR_DEC = 10'd22;
	localparam logic [NUM_W-1:0] SPR_SRR0 = 10'd26;
	localparam logic [NUM_W-1:0] SPR_SRR1 = 10'd27;
	localparam logic [NUM_W-1:0] SPR_TBL_R = 10'd268;
	localparam logic [NUM_W-1:0] SPR_TBU_R = 10'd269;
	localparam logic [NUM_W-1:0] SPR_SPRG0 = 10'd272;
	localparam logic [NUM_W-1:0] SPR_SPRG1 = 10'd273;
	localparam logic [NUM_W-1:0] SPR_SPRG2 = 10'd274;
	localparam logic [NUM_W-1:0] SPR_SPRG3 = 10'd275;
	localparam logic [NUM_W-1:0] SPR_TBL_W = 10'd284;
	localparam logic [NUM_W-1:0] SPR_TBU_W = 10'd285;
	localparam logic [NUM_W-1:0] SPR_LBAT_LO = 10'd528;
	localparam logic [NUM_W-1:0] SPR_LBAT_HI = 10'd543;
	localparam logic [NUM_W-1:0] SPR_UBAT_LO = 10'd560;
	localparam logic [NUM_W-1:0] SPR_UBAT_HI = 10'd575;
	localparam logic [NUM_W-1:0] SPR_GQR_LO = 10'd912;
	localparam logic [NUM_W-1:0] SPR_GQR_HI = 10'd919;
	localparam logic [NUM_W-1:0] SPR_HID2 = 10'd920;
	localparam logic [NUM_W-1:0] SPR_MMCR0 = 10'd952;
	localparam logic [NUM_W-1:0] SPR_PMC1 = 10'd953;
	localparam logic [NUM_W-1:0] SPR_PMC2 = 10'd954;
	localparam logic [NUM_W-1:0] SPR_MMCR1 = 10'd956;
	localparam logic [NUM_W-1:0] SPR_PMC3 = 10'd957;
	localparam logic [NUM_W-1:0] SPR_PMC4 = 10'd958;
	localparam logic [NUM_W-1:0] SPR_HID0 = 10'd1008;
	localparam logic [NUM_W-1:0] SPR_HID4 = 10'd1011;
	localparam logic [NUM_W-1:0] SPR_L2CR = 10'd1017;

	// decoded SPR number
	typedef struct packed {
		logic              known;
		logic              gated;
		logic [GATE_W-1:0] gate_bit;
		logic [IDX_W-1:0]  idx;
	} spr_dec_t;

	// map an SPR number to its store entry and gating group
	function automatic spr_dec_t spr_decode(input logic [NUM_W-1:0] n);
		spr_dec_t d;
		d.known = 1'b1;
		d.gated = 1'b0;
		d.gate_bit = CAP_HID2;
		d.idx = '0;
		unique case (n)
			SPR_XER: d.idx = 6'd0;
			SPR_LR: d.idx = 6'd1;
			SPR_CTR: d.idx = 6'd2;
			SPR_DEC: d.idx = 6'd3;
			SPR_SRR0: d.idx = 6'd4;
			SPR_SRR1: d.idx = 6'd5;
			SPR_SPRG0, SPR_SPRG1, SPR_SPRG2, SPR_SPRG3: d.idx = 6'd6 + IDX_W'(n - SPR_SPRG0);
			SPR_HID0: d.idx = 6'd10;
			SPR_TBL_R, SPR_TBL_W: d.idx = 6'd11;
			SPR_TBU_R, SPR_TBU_W: d.idx = 6'd12;
			SPR_HID2: begin
				d.idx = 6'd13; d.gated = 1'b1; d.gate_bit = CAP_HID2;
			end
			SPR_HID4: begin
				d.idx = 6'd14; d.gated = 1'b1; d.gate_bit = CAP_HID4;
			end
			SPR_L2CR: begin
				d.idx = 6'd55; d.gated = 1'b1; d.gate_bit = CAP_L2CR;
			end
			SPR_MMCR0: begin
				d.idx = 6'd56; d.gated = 1'b1; d.gate_bit = CAP_PMON;
			end
			SPR_PMC1: begin
				d.idx = 6'd57; d.gated = 1'b1; d.gate_bit = CAP_PMON;
			end
			SPR_PMC2: begin
				d.idx = 6'd58; d.gated = 1'b1; d.gate_bit = CAP_PMON;
			end
			SPR_MMCR1: begin
				d.idx = 6'd59; d.gated = 1'b1; d.gate_bit = CAP_PMON;
			end
			SPR_PMC3: begin
				d.idx = 6'd60; d.gated = 1'b1; d.gate_bit = CAP_PMON;
			end
			SPR_PMC4: begin
				d.idx = 6'd61; d.gated = 1'b1; d.gate_bit = CAP_PMON;
			end
			default: begin
				// BAT and GQR ranges
				if (n >= SPR_LBAT_LO && n <= SPR_LBAT_HI) begin
					d.idx = 6'd15 + IDX_W'(n - SPR_LBAT_LO);
				end else if (n >= SPR_UBAT_LO && n <= SPR_UBAT_HI) begin
					d.idx = 6'd31 + IDX_W'(n - SPR_UBAT_LO);
					d.gated = 1'b1;
					d.gate_bit = CAP_UBAT;
				end else if (n >= SPR_GQR_LO && n <= SPR_GQR_HI) begin
					d.idx = 6'd47 + IDX_W'(n - SPR_GQR_LO);
					d.gated = 1'b1;
					d.gate_bit = CAP_GQR;
				end else begin
					d.known = 1'b0;
				end
			end
		endcase
		return d;
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/sau_store.sv
// ---------------------------------------------------------------------------
// sau_store: SPR backing store
// Single-port memory with a registered read and per-entry valid bits, so
// that entries never written since reset read as zero.
// ---------------------------------------------------------------------------
`default_nettype none

module sau_store #(
	parameter int ENTRIES = 64,
	parameter int DW = 32,
	parameter int AW = $clog2(ENTRIES)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          access,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] addr,
	input  wire logic [DW-1:0] wdata,
	output logic      [DW-1:0] rdata
);

	logic [DW-1:0]      mem [ENTRIES];
	logic [DW-1:0]      rdata_q;
	logic [ENTRIES-1:0] vld_q;
	logic               rvld_q;

	// memory array: write and registered read at one address
	always_ff @(posedge clk) begin
		if (access) begin
			if (wr_en) begin
				mem[addr] <= wdata;
			end
			rdata_q <= mem[addr];
		end
	end

	// written-since-reset flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rvld_q <= 1'b0;
		end else if (access) begin
			if (wr_en) begin
				vld_q[addr] <= 1'b1;
			end
			rvld_q <= vld_q[addr];
		end
	end

	// entries never written read as zero
	assign rdata = rvld_q ? rdata_q : '0;

endmodule

`default_nettype wire

// File: hw/rtl/spr_access_unit.sv
// ---------------------------------------------------------------------------
// spr_access_unit: special-purpose register file
// Executes move-to and move-from SPR items against an internal store,
// gating optional register groups by a capability mask.
// ---------------------------------------------------------------------------
//  channel   | ports                                          | handshake
//  ----------+------------------------------------------------+----------------
//  item in   | action, spr_number, write_value, gpr_index     | start && !busy
//  result    | read_value, write_back, target_gpr,            | done, one cycle
//            | program_fault                                  |
//  config    | cfg_wdata (capability mask)                    | cfg_we
//
//  One item per cycle; each result appears in the cycle after its item is taken,
//  set by the single registered read of the store. busy stays low.
//  A move-from sees every move-to accepted in an earlier cycle.
//  Reset clears the capability mask and marks every store entry as zero
//  through per-entry valid bits; no clearing pass is needed.
//  Results cannot be stalled: done is high for exactly one cycle per item.
// ---------------------------------------------------------------------------
`default_nettype none

module spr_access_unit #(
	parameter int SPR_ENTRIES = sau_pkg::SPR_ENTRIES_DEF,
	parameter int DATA_WIDTH = sau_pkg::DATA_WIDTH_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	output logic                            busy,
	input  wire logic                       action,
	input  wire logic [sau_pkg::NUM_W-1:0]  spr_number,
	input  wire logic [sau_pkg::VAL_W-1:0]  write_value,
	input  wire logic [sau_pkg::GPR_W-1:0]  gpr_index,
	input  wire logic                       cfg_we,
	input  wire logic [sau_pkg::CAP_W-1:0]  cfg_wdata,
	output logic                            done,
	output logic      [sau_pkg::VAL_W-1:0]  read_value,
	output logic                            write_back,
	output logic      [sau_pkg::GPR_W-1:0]  target_gpr,
	output logic                            program_fault
);

	import sau_pkg::*;

	localparam int AW = $clog2(SPR_ENTRIES);

	logic [CAP_W-1:0]  cap_q;
	logic              accept;
	spr_dec_t          dec;
	logic              in_range;
	logic              enabled;
	logic              ok;
	logic              st_wr;
	logic [DATA_WIDTH-1:0] st_rdata;
	logic              done_s1;
	logic              fault_s1;
	logic              rd_s1;
	logic [GPR_W-1:0]  gpr_s1;

	assign busy = 1'b0;
	assign accept = start && !busy;

	// capability mask register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= '0;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	// decode and permission check
	always_comb begin
		dec = spr_decode(spr_number);
		in_range = int'(dec.idx) < SPR_ENTRIES;
		enabled = !dec.gated || cap_q[dec.gate_bit];
		ok = dec.known && in_range && enabled;
		st_wr = ok && (action == ACT_MTSPR);
	end

	// backing store
	sau_store #(
		.ENTRIES(SPR_ENTRIES),
		.DW(DATA_WIDTH),
		.AW(AW)
	) u_store (
		.clk(clk),
		.arst_n(arst_n),
		.access(accept && ok),
		.wr_en(st_wr),
		.addr(AW'(dec.idx)),
		.wdata(DATA_WIDTH'(write_value)),
		.rdata(st_rdata)
	);

	// result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s1 <= 1'b0;
			fault_s1 <= 1'b0;
			rd_s1 <= 1'b0;
			gpr_s1 <= '0;
		end else begin
			done_s1 <= accept;
			fault_s1 <= accept && !ok;
			rd_s1 <= accept && ok && (action == ACT_MFSPR);
			gpr_s1 <= (ok && (action == ACT_MFSPR)) ? gpr_index : '0;
		end
	end

	// result ports
	assign done = done_s1;
	assign program_fault = fault_s1;
	assign write_back = rd_s1;
	assign target_gpr = rd_s1 ? gpr_s1 : '0;
	assign read_value = rd_s1 ? st_rdata[VAL_W-1:0] : '0;

`ifndef ASSERT_OFF
	a_result_follows_item: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done)
		else $error("result missing after accepted item");
	a_no_spurious_result: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> !done)
		else $error("result without accepted item");
	a_fault_excl: assert property (@(posedge clk) disable iff (!arst_n)
		program_fault |-> (done && !write_back && read_value == '0 && target_gpr == '0))
		else $error("faulting item carries data");
	a_unknown_faults: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !dec.known) |=> program_fault)
		else $error("unknown spr number did not fault");
`endif

endmodule

`default_nettype wire

// File: tb/sv/spr_access_unit_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spr_access_unit_test: self-checking bench for the SPR access unit
// Drives move-to and move-from SPR items through the start/busy port and
// predicts each result with a local copy of the register store and the
// capability mask. Directed tests cover reset contents, timebase aliases,
// unknown numbers and every gated group; random traffic then runs under
// several masks with the sender idling at different rates.
// ---------------------------------------------------------------------------

module spr_access_unit_test;
	import sau_pkg::*;

	localparam int QUIET_LIMIT = 1000;
	localparam int END_WAIT = 100;
	localparam int CHUNK_ITEMS = 92;
	localparam int CHUNKS = 4;
	localparam int STORE_DEPTH = 64;
	localparam int REPORT_LIMIT = 50;

	typedef struct packed {
		logic [VAL_W-1:0] value;
		logic             wb;
		logic [GPR_W-1:0] gpr;
		logic             fault;
	} spr_result_t;

	// block ports
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic action = ACT_MTSPR;
	logic [NUM_W-1:0] spr_number = '0;
	logic [VAL_W-1:0] write_value = '0;
	logic [GPR_W-1:0] gpr_index = '0;
	logic cfg_we = 1'b0;
	logic [CAP_W-1:0] cfg_wdata = '0;
	logic busy;
	logic done;
	logic [VAL_W-1:0] read_value;
	logic write_back;
	logic [GPR_W-1:0] target_gpr;
	logic program_fault;

	// predictor state and bookkeeping
	logic [VAL_W-1:0] spr_store [STORE_DEPTH];
	logic [CAP_W-1:0] cap_model;
	spr_result_t pending_results[$];
	int fail_count = 0;
	int idle_pct = 0;
	int quiet_cycles = 0;
	bit start_on = 1'b0;

	spr_access_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.action(action),
		.spr_number(spr_number),
		.write_value(write_value),
		.gpr_index(gpr_index),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.done(done),
		.read_value(read_value),
		.write_back(write_back),
		.target_gpr(target_gpr),
		.program_fault(program_fault)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// map an SPR number to its store entry and the mask bit it needs
	function automatic bit locate_spr(input logic [NUM_W-1:0] n, output int entry,
			output logic [CAP_W-1:0] need);
		need = '0;
		entry = 0;
		if (n >= SPR_LBAT_LO && n <= SPR_LBAT_HI) begin
			entry = 15 + int'(n - SPR_LBAT_LO);
			return 1'b1;
		end
		if (n >= SPR_UBAT_LO && n <= SPR_UBAT_HI) begin
			entry = 31 + int'(n - SPR_UBAT_LO);
			need[CAP_UBAT] = 1'b1;
			return 1'b1;
		end
		if (n >= SPR_GQR_LO && n <= SPR_GQR_HI) begin
			entry = 47 + int'(n - SPR_GQR_LO);
			need[CAP_GQR] = 1'b1;
			return 1'b1;
		end
		case (n)
			SPR_XER: entry = 0;
			SPR_LR: entry = 1;
			SPR_CTR: entry = 2;
			SPR_DEC: entry = 3;
			SPR_SRR0: entry = 4;
			SPR_SRR1: entry = 5;
			SPR_SPRG0, SPR_SPRG1, SPR_SPRG2, SPR_SPRG3: entry = 6 + int'(n - SPR_SPRG0);
			SPR_HID0: entry = 10;
			SPR_TBL_R, SPR_TBL_W: entry = 11;
			SPR_TBU_R, SPR_TBU_W: entry = 12;
			SPR_HID2: begin
				entry = 13;
				need[CAP_HID2] = 1'b1;
			end
			SPR_HID4: begin
				entry = 14;
				need[CAP_HID4] = 1'b1;
			end
			SPR_L2CR: begin
				entry = 55;
				need[CAP_L2CR] = 1'b1;
			end
			SPR_MMCR0, SPR_PMC1, SPR_PMC2, SPR_MMCR1, SPR_PMC3, SPR_PMC4: begin
				entry = 56 + int'(n - SPR_MMCR0) - ((n > SPR_PMC2) ? 1 : 0);
				need[CAP_PMON] = 1'b1;
			end
			default: return 1'b0;
		endcase
		return 1'b1;
	endfunction

	// execute one move against the local store and give the expected result
	function automatic spr_result_t execute_spr_move(input logic act,
			input logic [NUM_W-1:0] n, input logic [VAL_W-1:0] wval,
			input logic [GPR_W-1:0] gidx);
		spr_result_t r;
		int entry;
		logic [CAP_W-1:0] need;
		bit ok;
		r = '0;
		ok = locate_spr(n, entry, need);
		if (!ok || (need & ~cap_model) != '0 || entry >= STORE_DEPTH) begin
			r.fault = 1'b1;
			return r;
		end
		if (act == ACT_MTSPR) begin
			spr_store[entry] = wval;
		end else begin
			r.value = spr_store[entry];
			r.wb = 1'b1;
			r.gpr = gidx;
		end
		return r;
	endfunction

	// random number from the known set
	function automatic logic [NUM_W-1:0] pick_known_spr();
		case ($urandom_range(0, 7))
			0: return SPR_LBAT_LO + NUM_W'($urandom_range(0, 15));
			1: return SPR_UBAT_LO + NUM_W'($urandom_range(0, 15));
			2: return SPR_GQR_LO + NUM_W'($urandom_range(0, 7));
			3: return SPR_SPRG0 + NUM_W'($urandom_range(0, 3));
			4: begin
				case ($urandom_range(0, 3))
					0: return SPR_TBL_R;
					1: return SPR_TBU_R;
					2: return SPR_TBL_W;
					default: return SPR_TBU_W;
				endcase
			end
			5: begin
				case ($urandom_range(0, 5))
					0: return SPR_XER;
					1: return SPR_LR;
					2: return SPR_CTR;
					3: return SPR_DEC;
					4: return SPR_SRR0;
					default: return SPR_SRR1;
				endcase
			end
			6: begin
				case ($urandom_range(0, 3))
					0: return SPR_HID0;
					1: return SPR_HID2;
					2: return SPR_HID4;
					default: return SPR_L2CR;
				endcase
			end
			default: begin
				case ($urandom_range(0, 5))
					0: return SPR_MMCR0;
					1: return SPR_PMC1;
					2: return SPR_PMC2;
					3: return SPR_MMCR1;
					4: return SPR_PMC3;
					default: return SPR_PMC4;
				endcase
			end
		endcase
	endfunction

	// present one item, wait for it to be taken, then predict its result
	task automatic send_item(input logic act, input logic [NUM_W-1:0] n,
			input logic [VAL_W-1:0] wval, input logic [GPR_W-1:0] gidx);
		int gap;
		if ($urandom_range(0, 99) < idle_pct) begin
			gap = $urandom_range(1, 3);
			if (start_on) begin
				start <= 1'b0;
				start_on = 1'b0;
			end
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		start_on = 1'b1;
		action <= act;
		spr_number <= n;
		write_value <= wval;
		gpr_index <= gidx;
		do @(posedge clk); while (busy !== 1'b0);
		pending_results.push_back(execute_spr_move(act, n, wval, gidx));
	endtask

	task automatic stop_items();
		if (start_on) begin
			start <= 1'b0;
			start_on = 1'b0;
		end
	endtask

	// hold off the sender until every predicted result has come back
	task automatic drain_results();
		stop_items();
		while (pending_results.size() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	task automatic write_capability(input logic [CAP_W-1:0] mask);
		drain_results();
		cfg_we <= 1'b1;
		cfg_wdata <= mask;
		@(posedge clk);
		cfg_we <= 1'b0;
		cap_model = mask;
	endtask

	// mostly well-formed numbers, some near misses and random noise
	task automatic send_random_item();
		logic [NUM_W-1:0] n;
		logic [VAL_W-1:0] v;
		case ($urandom_range(0, 9))
			0: n = NUM_W'($urandom);
			1: n = $urandom_range(0, 1) ? pick_known_spr() + 1'b1 : pick_known_spr() - 1'b1;
			default: n = pick_known_spr();
		endcase
		case ($urandom_range(0, 7))
			0: v = '0;
			1: v = '1;
			default: v = $urandom;
		endcase
		send_item(logic'($urandom_range(0, 1)), n, v, GPR_W'($urandom_range(0, 31)));
	endtask

	task automatic compare_field(input string name, input logic [VAL_W-1:0] want,
			input logic [VAL_W-1:0] got);
		if (want !== got) begin
			fail_count++;
			if (fail_count <= REPORT_LIMIT)
				$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
		end
	endtask

	// compare each result strobe with the oldest prediction
	always @(posedge clk) begin : result_check
		spr_result_t want;
		if (arst_n && done === 1'b1) begin
			if (pending_results.size() == 0) begin
				fail_count++;
				if (fail_count <= REPORT_LIMIT)
					$display("%0t: unexpected result, expected none, actual %h %b %0d %b",
						$time, read_value, write_back, target_gpr, program_fault);
			end else begin
				want = pending_results.pop_front();
				compare_field("read_value", want.value, read_value);
				compare_field("write_back", VAL_W'(want.wb), VAL_W'(write_back));
				compare_field("target_gpr", VAL_W'(want.gpr), VAL_W'(target_gpr));
				compare_field("program_fault", VAL_W'(want.fault), VAL_W'(program_fault));
			end
		end
	end

	// watchdog on cycles with no handshake at all
	always @(posedge clk) begin
		if ((start && busy === 1'b0) || done === 1'b1)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: timeout after %0d quiet cycles", $time, quiet_cycles);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// store reads zero and gated groups are off after reset
	task automatic test_reset_state();
		idle_pct = 0;
		send_item(ACT_MFSPR, SPR_XER, '0, 5'd31);
		send_item(ACT_MFSPR, SPR_HID0, '0, 5'd0);
		send_item(ACT_MFSPR, SPR_HID2, '0, 5'd3);
	endtask

	// timebase aliases share entries, unknown numbers fault and write nothing
	task automatic test_aliases_and_unknown();
		send_item(ACT_MTSPR, SPR_LR, '1, 5'd0);
		send_item(ACT_MFSPR, SPR_LR, '0, 5'd0);
		send_item(ACT_MTSPR, SPR_TBL_W, 32'hA5A5_5A5A, 5'd31);
		send_item(ACT_MFSPR, SPR_TBL_R, '0, 5'd7);
		send_item(ACT_MTSPR, SPR_TBU_R, 32'h1234_5678, 5'd0);
		send_item(ACT_MFSPR, SPR_TBU_W, '0, 5'd30);
		send_item(ACT_MTSPR, SPR_PMC2 + 1'b1, '1, 5'd0);
		send_item(ACT_MFSPR, SPR_PMC2 + 1'b1, '0, 5'd9);
		send_item(ACT_MFSPR, 10'd0, '0, 5'd1);
		send_item(ACT_MTSPR, 10'h3FF, '1, 5'd31);
	endtask

	// every gated group works when enabled; L2CR faults once all are disabled
	task automatic test_capability_groups();
		logic [NUM_W-1:0] gated [6] = '{SPR_HID2, SPR_HID4, SPR_UBAT_HI, SPR_GQR_LO,
			SPR_L2CR, SPR_PMC4};
		write_capability(6'h3F);
		foreach (gated[i]) begin
			send_item(ACT_MTSPR, gated[i], $urandom, GPR_W'(i));
			send_item(ACT_MFSPR, gated[i], '0, GPR_W'(31 - i));
		end
		write_capability(6'h00);
		send_item(ACT_MFSPR, SPR_L2CR, '0, 5'd4);
	endtask

	// random traffic under several masks and sender idle rates
	task automatic test_random_traffic();
		int rates [3] = '{12, 83, 0};
		logic [CAP_W-1:0] mask;
		foreach (rates[p]) begin
			idle_pct = rates[p];
			for (int c = 0; c < CHUNKS; c++) begin
				case (c)
					0: mask = 6'h3F;
					2: mask = 6'h00;
					default: mask = CAP_W'($urandom_range(0, 63));
				endcase
				write_capability(mask);
				for (int k = 0; k < CHUNK_ITEMS; k++)
					send_random_item();
			end
		end
	endtask

	initial begin
		for (int i = 0; i < STORE_DEPTH; i++)
			spr_store[i] = '0;
		cap_model = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_aliases_and_unknown();
		test_capability_groups();
		test_random_traffic();

		// let the last results come back
		stop_items();
		for (int n = 0; n < END_WAIT && pending_results.size() != 0; n++)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (pending_results.size() != 0) begin
			fail_count += pending_results.size();
			$display("%0t: %0d expected results never arrived", $time, pending_results.size());
		end
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// File: files.f
hw/rtl/sau_pkg.sv
hw/rtl/sau_store.sv
hw/rtl/spr_access_unit.sv
tb/sv/spr_access_unit_test.sv
